// ----- rtl/srs_pkg.sv -----
// Shared types and constants for the script region scanner.
`default_nettype none
package srs_pkg;

  localparam int unsigned POS_W = 32;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned MODE_W = 2;
  localparam int unsigned MATCH_W = 3;

  localparam logic [MODE_W-1:0] MODE_BEFORE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CODE   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd2;
  localparam logic [MODE_W-1:0] MODE_DONE   = 2'd3;

  localparam logic [MATCH_W-1:0] MP_NONE  = 3'd0;
  localparam logic [MATCH_W-1:0] MP_LT    = 3'd1;
  localparam logic [MATCH_W-1:0] MP_QMARK = 3'd2;
  localparam logic [MATCH_W-1:0] MP_P     = 3'd3;
  localparam logic [MATCH_W-1:0] MP_PH    = 3'd4;
  localparam logic [MATCH_W-1:0] MP_CLOSE_Q = 3'd1;

  localparam logic [BYTE_W-1:0] CH_LT = 8'h3C;
  localparam logic [BYTE_W-1:0] CH_QM = 8'h3F;
  localparam logic [BYTE_W-1:0] CH_GT = 8'h3E;
  localparam logic [BYTE_W-1:0] CH_EQ = 8'h3D;
  localparam logic [BYTE_W-1:0] CH_P  = 8'h70;
  localparam logic [BYTE_W-1:0] CH_H  = 8'h68;

  localparam logic [POS_W-1:0] POS_MAX = 32'hFFFF_FFFF;
  // Opener length minus one for "<?=" and "<?php".
  localparam logic [POS_W-1:0] BACK_SHORT = 32'd2;
  localparam logic [POS_W-1:0] BACK_LONG  = 32'd4;

  typedef struct packed {
    logic             has_region;
    logic [POS_W-1:0] region_start;
    logic [POS_W-1:0] region_length;
    logic             unterminated;
    logic             final_record;
  } res_t;

endpackage
`default_nettype wire

// ----- rtl/srs_in_if.sv -----
// Input byte channel of the script region scanner.
`default_nettype none
interface srs_in_if;
  logic                          valid;
  logic                          ready;
  logic [srs_pkg::BYTE_W-1:0]    data_byte;
  logic                          last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface
`default_nettype wire

// ----- rtl/srs_out_if.sv -----
// Region record channel of the script region scanner.
`default_nettype none
interface srs_out_if;
  logic                        valid;
  logic                        ready;
  logic                        has_region;
  logic [srs_pkg::POS_W-1:0]   region_start;
  logic [srs_pkg::POS_W-1:0]   region_length;
  logic                        unterminated;
  logic                        final_record;

  modport source (output valid, output has_region, output region_start,
                  output region_length, output unterminated, output final_record,
                  input ready);
  modport sink (input valid, input has_region, input region_start,
                input region_length, input unterminated, input final_record,
                output ready);
endinterface
`default_nettype wire

// ----- rtl/script_region_scanner.sv -----
// Script region scanner: one byte per cycle when not stalled, reports code regions of an object.
// A record is registered in the output register, or in the skid stage while out_ch stalls, before it appears on out_ch.
// Throughput: one byte beat per cycle while the skid stage is empty; the single
// scan stage updates all state in one step, and an output register plus skid
// stage absorb output stalls. Reset: synchronous active-low rst_n clears scan
// state, the record buffer valid flags and start_position (to 0); no clearing pass.
`default_nettype none
module script_region_scanner #(
  parameter int unsigned MAX_REGIONS = 16
) (
  input  wire                        clk,
  input  wire                        rst_n,
  srs_in_if.sink                     in_ch,
  srs_out_if.source                  out_ch,
  input  wire                        cfg_wr_en,
  input  wire [srs_pkg::POS_W-1:0]   cfg_wr_data
);
  import srs_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_REGIONS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_REGIONS);

  logic [POS_W-1:0]   start_pos_r;
  logic [MODE_W-1:0]  mode_r, mode_nxt;
  logic [MATCH_W-1:0] mp_r, mp_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [POS_W-1:0]   ors_r, ors_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic               skid_valid_r, skid_valid_nxt;
  res_t               out_res_r, out_res_nxt;
  res_t               skid_res_r, skid_res_nxt;

  logic               in_acc;
  logic               out_take;
  logic               emit;
  res_t               res;
  logic [MODE_W-1:0]  mode_a;
  logic [MATCH_W-1:0] mp_a;
  logic [POS_W-1:0]   ors_a;
  logic [POS_W-1:0]   span_d;
  logic [POS_W-1:0]   span_len;
  logic [POS_W-1:0]   back;
  logic               open_now;
  logic [CNT_W-1:0]   cnt_inc;
  logic [BYTE_W-1:0]  b;

  assign in_ch.ready = !skid_valid_r;
  assign in_acc      = in_ch.valid && !skid_valid_r;
  assign out_take    = out_valid_r && out_ch.ready;
  assign b           = in_ch.data_byte;
  assign cnt_inc     = cnt_r + CNT_W'(1);

  always_comb begin
    mode_a = mode_r;
    mp_a   = mp_r;
    ors_a  = ors_r;
    if (mode_r == MODE_BEFORE && pos_r >= start_pos_r) begin
      mode_a = MODE_CODE;
      mp_a   = MP_NONE;
      ors_a  = pos_r;
    end
  end

  always_comb begin
    mode_nxt = mode_a;
    mp_nxt   = mp_a;
    ors_nxt  = ors_a;
    cnt_nxt  = cnt_r;
    emit     = 1'b0;
    open_now = 1'b0;
    back     = BACK_SHORT;
    res      = '0;
    unique case (mode_a)
      MODE_CODE: begin
        if (mp_a == MP_CLOSE_Q && b == CH_GT) begin
          emit            = 1'b1;
          res.has_region  = 1'b1;
          cnt_nxt         = cnt_inc;
          mode_nxt        = (cnt_inc >= CNT_MAX) ? MODE_DONE : MODE_SEARCH;
          mp_nxt          = MP_NONE;
        end else begin
          mp_nxt = (b == CH_QM) ? MP_CLOSE_Q : MP_NONE;
        end
      end
      MODE_SEARCH: begin
        mp_nxt = (b == CH_LT) ? MP_LT : MP_NONE;
        priority if (mp_a == MP_LT && b == CH_QM) begin
          mp_nxt = MP_QMARK;
        end else if (mp_a == MP_QMARK && b == CH_EQ) begin
          open_now = 1'b1;
          back     = BACK_SHORT;
        end else if (mp_a == MP_QMARK && b == CH_P) begin
          mp_nxt = MP_P;
        end else if (mp_a == MP_P && b == CH_H) begin
          mp_nxt = MP_PH;
        end else if (mp_a == MP_PH && b == CH_P) begin
          open_now = 1'b1;
          back     = BACK_LONG;
        end else begin
        end
        if (open_now) begin
          ors_nxt  = (pos_r >= back) ? pos_r - back : '0;
          mode_nxt = MODE_CODE;
          mp_nxt   = MP_NONE;
        end
      end
      MODE_BEFORE, MODE_DONE: begin
      end
      default: begin
      end
    endcase

    span_d   = pos_r - ors_nxt;
    span_len = (pos_r < ors_nxt) ? '0 :
               (span_d == POS_MAX) ? POS_MAX : span_d + POS_W'(1);

    if (emit) begin
      res.region_start  = ors_nxt;
      res.region_length = span_len;
    end

    if (in_ch.last_byte) begin
      if (!emit && mode_nxt == MODE_CODE) begin
        res.has_region    = 1'b1;
        res.region_start  = ors_nxt;
        res.region_length = span_len;
        res.unterminated  = 1'b1;
      end
      emit             = 1'b1;
      res.final_record = 1'b1;
      mode_nxt         = MODE_BEFORE;
      mp_nxt           = MP_NONE;
      ors_nxt          = '0;
      cnt_nxt          = '0;
      pos_nxt          = '0;
    end else begin
      pos_nxt = (pos_r == POS_MAX) ? pos_r : pos_r + POS_W'(1);
    end
  end

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_res_nxt    = out_res_r;
    skid_valid_nxt = skid_valid_r;
    skid_res_nxt   = skid_res_r;
    if (!out_valid_r || out_take) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_res_nxt    = skid_res_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = in_acc && emit;
        out_res_nxt   = res;
      end
    end else if (in_acc && emit) begin
      skid_valid_nxt = 1'b1;
      skid_res_nxt   = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_pos_r  <= '0;
      mode_r       <= MODE_BEFORE;
      mp_r         <= MP_NONE;
      pos_r        <= '0;
      ors_r        <= '0;
      cnt_r        <= '0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        start_pos_r <= cfg_wr_data;
      end
      if (in_acc) begin
        mode_r <= mode_nxt;
        mp_r   <= mp_nxt;
        pos_r  <= pos_nxt;
        ors_r  <= ors_nxt;
        cnt_r  <= cnt_nxt;
      end
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r  <= out_res_nxt;
    skid_res_r <= skid_res_nxt;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.has_region    = out_res_r.has_region;
  assign out_ch.region_start  = out_res_r.region_start;
  assign out_ch.region_length = out_res_r.region_length;
  assign out_ch.unterminated  = out_res_r.unterminated;
  assign out_ch.final_record  = out_res_r.final_record;

endmodule
`default_nettype wire

// ----- tb/tb_script_region_scanner.sv -----
// Self-checking testbench for the script region scanner: directed table, then random objects.
`default_nettype none
module tb_script_region_scanner;
  timeunit 1ns;
  timeprecision 1ps;

  import srs_pkg::*;

  localparam int unsigned REGION_CAP = 16;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned CYCLE_LIMIT = 400_000;
  localparam int unsigned PHASES = 8;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
  } beat_t;

  typedef struct {
    bit               is_cfg;
    logic [POS_W-1:0] cfg_val;
    beat_t            beat;
    bit               typed;
    res_t             want;
  } step_t;

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic [POS_W-1:0] cfg_wr_data;

  srs_in_if  in_ch ();
  srs_out_if out_ch ();

  script_region_scanner #(
    .MAX_REGIONS(REGION_CAP)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // scanner state mirrored on the testbench side
  logic [POS_W-1:0]   start_cfg = '0;
  logic [MODE_W-1:0]  scan_state = MODE_BEFORE;
  logic [MATCH_W-1:0] seq_match = MP_NONE;
  logic [POS_W-1:0]   cur_pos = '0;
  logic [POS_W-1:0]   open_start = '0;
  int unsigned        closed_regions = 0;

  res_t        due_records[$];
  beat_t       byte_stream[$];
  logic        use_typed;
  res_t        typed_rec;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit          pressure_armed = 1'b0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  logic        model_emit;
  res_t        model_rec;
  res_t        head_rec;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [POS_W-1:0] span_len(input logic [POS_W-1:0] from,
                                                input logic [POS_W-1:0] to);
    if (to < from) return '0;
    if (to - from == POS_MAX) return POS_MAX;
    return to - from + 1'b1;
  endfunction

  function automatic void open_region(input logic [POS_W-1:0] pos,
                                      input logic [POS_W-1:0] back);
    open_start = (pos >= back) ? pos - back : '0;
    scan_state = MODE_CODE;
  endfunction

  function automatic void scan_byte(input logic [BYTE_W-1:0] b, input logic last_in,
                                    output logic emit, output res_t rec);
    logic [POS_W-1:0]   pos;
    logic [MATCH_W-1:0] nxt;
    pos = cur_pos;
    emit = 1'b0;
    rec = '0;
    if (scan_state == MODE_BEFORE && pos >= start_cfg) begin
      scan_state = MODE_CODE;
      open_start = pos;
      seq_match = MP_NONE;
    end
    if (scan_state == MODE_CODE) begin
      if (seq_match == MP_CLOSE_Q && b == CH_GT) begin
        emit = 1'b1;
        rec.has_region = 1'b1;
        rec.region_start = open_start;
        rec.region_length = span_len(open_start, pos);
        closed_regions++;
        scan_state = (closed_regions >= REGION_CAP) ? MODE_DONE : MODE_SEARCH;
        seq_match = MP_NONE;
      end else begin
        seq_match = (b == CH_QM) ? MP_CLOSE_Q : MP_NONE;
      end
    end else if (scan_state == MODE_SEARCH) begin
      nxt = (b == CH_LT) ? MP_LT : MP_NONE;
      if (seq_match == MP_LT && b == CH_QM) begin
        nxt = MP_QMARK;
      end else if (seq_match == MP_QMARK && b == CH_EQ) begin
        open_region(pos, BACK_SHORT);
        nxt = MP_NONE;
      end else if (seq_match == MP_QMARK && b == CH_P) begin
        nxt = MP_P;
      end else if (seq_match == MP_P && b == CH_H) begin
        nxt = MP_PH;
      end else if (seq_match == MP_PH && b == CH_P) begin
        open_region(pos, BACK_LONG);
        nxt = MP_NONE;
      end
      seq_match = nxt;
    end
    if (last_in) begin
      if (!emit && scan_state == MODE_CODE) begin
        rec.has_region = 1'b1;
        rec.region_start = open_start;
        rec.region_length = span_len(open_start, pos);
        rec.unterminated = 1'b1;
      end
      emit = 1'b1;
      rec.final_record = 1'b1;
      scan_state = MODE_BEFORE;
      seq_match = MP_NONE;
      cur_pos = '0;
      open_start = '0;
      closed_regions = 0;
    end else if (cur_pos != POS_MAX) begin
      cur_pos = cur_pos + 1'b1;
    end
  endfunction

  function automatic res_t record(input logic has, input logic [POS_W-1:0] start,
                                  input logic [POS_W-1:0] len, input logic unterm,
                                  input logic fin);
    res_t r;
    r.has_region = has;
    r.region_start = start;
    r.region_length = len;
    r.unterminated = unterm;
    r.final_record = fin;
    return r;
  endfunction

  function automatic step_t byte_step(input logic [BYTE_W-1:0] d, input logic l);
    step_t s;
    s = '{1'b0, '0, '{d, l}, 1'b0, '0};
    return s;
  endfunction

  function automatic step_t typed_step(input logic [BYTE_W-1:0] d, input logic l,
                                       input res_t want);
    step_t s;
    s = '{1'b0, '0, '{d, l}, 1'b1, want};
    return s;
  endfunction

  function automatic step_t cfg_step(input logic [POS_W-1:0] v);
    step_t s;
    s = '{1'b1, v, '0, 1'b0, '0};
    return s;
  endfunction

  function automatic void add_byte(input logic [BYTE_W-1:0] v);
    byte_stream.push_back('{v, 1'b0});
  endfunction

  function automatic void add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endfunction

  // one object of random length: mostly tag fragments, some noise, a few reaching the cap
  function automatic void build_object();
    string specials;
    int unsigned reps;
    specials = "<?>=ph";
    if ($urandom_range(0, 11) == 0) begin
      reps = $urandom_range(REGION_CAP - 1, REGION_CAP + 4);
      repeat (reps) begin
        add_text("<?=");
        repeat ($urandom_range(0, 2)) add_byte(BYTE_W'($urandom_range(0, 255)));
        add_text("?>");
      end
      repeat ($urandom_range(0, 3)) add_byte(BYTE_W'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(1, 10)) begin
        case ($urandom_range(0, 9))
          0: add_text("<?php");
          1: add_text("<?=");
          2, 3: add_text("?>");
          4: begin
            case ($urandom_range(0, 4))
              0: add_text("<?PHP");
              1: add_text("<?pHp");
              2: add_text("<?ph");
              3: add_text("< ?=");
              default: add_text("<?p");
            endcase
          end
          5: add_text("<?");
          6: add_byte(specials[$urandom_range(0, 5)]);
          default: repeat ($urandom_range(1, 4)) add_byte(BYTE_W'($urandom_range(0, 255)));
        endcase
      end
    end
    byte_stream[byte_stream.size() - 1].last = 1'b1;
  endfunction

  task automatic send_beat(input beat_t bt, input logic typed, input res_t want);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data_byte <= bt.data;
    in_ch.last_byte <= bt.last;
    use_typed <= typed;
    typed_rec <= want;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (due_records.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_start(input logic [POS_W-1:0] val);
    settle();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic set_idling(input int unsigned mode);
    case (mode)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
      default: begin send_idle_pct = 24; recv_stall_pct = 24; end
    endcase
  endtask

  // predict on every accepted byte; typed rows override the prediction
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_wr_en) start_cfg = cfg_wr_data;
      if (in_ch.valid && in_ch.ready) begin
        scan_byte(in_ch.data_byte, in_ch.last_byte, model_emit, model_rec);
        if (use_typed) due_records.push_back(typed_rec);
        else if (model_emit) due_records.push_back(model_rec);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (due_records.size() == 0) begin
        $error("region record with nothing expected: start %0h length %0h",
               out_ch.region_start, out_ch.region_length);
        mismatches++;
      end else begin
        head_rec = due_records.pop_front();
        if (out_ch.has_region !== head_rec.has_region) begin
          $error("has_region: expected %0d, got %0d", head_rec.has_region, out_ch.has_region);
          mismatches++;
        end
        if (out_ch.region_start !== head_rec.region_start) begin
          $error("region_start: expected %0h, got %0h",
                 head_rec.region_start, out_ch.region_start);
          mismatches++;
        end
        if (out_ch.region_length !== head_rec.region_length) begin
          $error("region_length: expected %0h, got %0h",
                 head_rec.region_length, out_ch.region_length);
          mismatches++;
        end
        if (out_ch.unterminated !== head_rec.unterminated) begin
          $error("unterminated: expected %0d, got %0d",
                 head_rec.unterminated, out_ch.unterminated);
          mismatches++;
        end
        if (out_ch.final_record !== head_rec.final_record) begin
          $error("final_record: expected %0d, got %0d",
                 head_rec.final_record, out_ch.final_record);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // result side: random stalls, plus one long hold so the input backs up
  initial begin : result_sink
    bit held;
    held = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (pressure_armed && !held) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        held = 1'b1;
      end
      out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  initial begin : stimulus
    step_t directed_steps[$];
    logic [POS_W-1:0] start_val;
    int unsigned n_items;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_ch.valid = 1'b0;
    in_ch.data_byte = '0;
    in_ch.last_byte = 1'b0;
    use_typed = 1'b0;
    typed_rec = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    directed_steps = '{
      typed_step("x", 1'b1, record(1'b1, 0, 1, 1'b1, 1'b1)),
      byte_step(CH_QM, 1'b0),
      typed_step(CH_GT, 1'b1, record(1'b1, 0, 2, 1'b0, 1'b1)),
      byte_step(CH_QM, 1'b0),
      typed_step(CH_GT, 1'b0, record(1'b1, 0, 2, 1'b0, 1'b0)),
      byte_step(CH_LT, 1'b0),
      byte_step(CH_QM, 1'b0),
      typed_step(CH_EQ, 1'b1, record(1'b1, 2, 3, 1'b1, 1'b1)),
      byte_step(8'hFF, 1'b0),
      byte_step(CH_QM, 1'b0),
      byte_step(CH_GT, 1'b0),
      byte_step(CH_LT, 1'b0),
      byte_step(CH_QM, 1'b0),
      byte_step(CH_P, 1'b0),
      byte_step(CH_H, 1'b0),
      byte_step(CH_P, 1'b0),
      byte_step(CH_GT, 1'b0),
      byte_step(CH_QM, 1'b0),
      byte_step(CH_GT, 1'b0),
      byte_step(CH_LT, 1'b0),
      byte_step(CH_QM, 1'b0),
      byte_step("P", 1'b0),
      typed_step(8'h00, 1'b1, record(1'b0, 0, 0, 1'b0, 1'b1)),
      cfg_step(32'd5),
      byte_step("a", 1'b0),
      typed_step(8'hFF, 1'b1, record(1'b0, 0, 0, 1'b0, 1'b1))
    };

    set_idling(3);
    foreach (directed_steps[i]) begin
      if (directed_steps[i].is_cfg) begin
        program_start(directed_steps[i].cfg_val);
      end else begin
        send_beat(directed_steps[i].beat, directed_steps[i].typed, directed_steps[i].want);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: start_val = '0;
        1: start_val = 32'd2;
        2: start_val = $urandom_range(0, 12);
        3: start_val = POS_MAX;
        4: start_val = $urandom();
        5: start_val = 32'd1;
        6: start_val = $urandom_range(0, 30);
        default: start_val = '0;
      endcase
      n_items = (ph == 3 || ph == 4) ? 60 : 260;
      program_start(start_val);
      set_idling(ph % 4);
      pressure_armed = (ph == 0);
      repeat (n_items) begin
        if (byte_stream.size() == 0) build_object();
        send_beat(byte_stream.pop_front(), 1'b0, '0);
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
`default_nettype wire
